>>> src/vsfb_pkg.sv
// ----------------------------------------------------------------------------
// vsfb_pkg: shared types and constants for the four-bone skinning unit
// Field widths, command codes and store geometry.
// ----------------------------------------------------------------------------
package vsfb_pkg;

  localparam int MaxBones   = 256;
  localparam int Influences = 4;
  localparam int PosWords   = 12;
  localparam int RotWords   = 9;
  localparam int MatWords   = PosWords + RotWords;
  localparam int BoneW      = $clog2(MaxBones);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SKIN = 1'b1
  } cmd_t;

  // s_tdata: load_bone, load_element, load_value, influence_bones,
  // influence_weights, pos_x..z, norm_x..z (tuser carries command)
  localparam int InW = 8 + 5 + 32 * 9;
  localparam int InBytesW = ((InW + 7) / 8) * 8;
  localparam int OutW = 32 * 3 + 18 * 3;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  typedef logic signed [31:0] q16_t;

endpackage

>>> src/vsfb_ram.sv
// ----------------------------------------------------------------------------
// vsfb_ram: generic single-port-write, one-read RAM
// Registered read.
// ----------------------------------------------------------------------------
module vsfb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/vertex_skinning_four_bone_unit.sv
// ----------------------------------------------------------------------------
// vertex_skinning_four_bone_unit: four-bone linear blend skinning
// Load requests fill the bone store; skin requests blend one vertex.
// ----------------------------------------------------------------------------
// channel | dir | handshake      | content
// s_*     | in  | tvalid/tready  | command in tuser, load and vertex fields
// m_*     | out | tvalid/tready  | blended position and unit normal
//
// One item enters every cycle unless the output stalls; 60 register stages
// in all (9 blend stages, 32 root steps, 18 divide steps, output register).
// Store reads are the first stage. The whole pipeline freezes when the
// output register is full and not taken; s_tready drops in that same cycle.
// Reset clears pipeline valids only; the bone store is undefined until
// written. Store ports are per influence and per word, so all words of a
// bone set are read in the same cycle; a load writes one word.
// A skin never sees a load that follows it; the store write happens at
// acceptance and reads are issued at acceptance, so a skin that follows a
// load sees it.
module vertex_skinning_four_bone_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tuser: command
  input  logic s_tuser,
  // tdata: load_bone[7:0], load_element[12:8], load_value[44:13],
  // influence_bones[76:45], influence_weights[108:77], pos_x, pos_y, pos_z,
  // norm_x, norm_y, norm_z (32 each from bit 109), zero fill
  input  logic [vsfb_pkg::InBytesW-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: out_pos_x, out_pos_y, out_pos_z (32 each), out_norm_x, out_norm_y,
  // out_norm_z (18 each), zero fill
  output logic [vsfb_pkg::OutBytesW-1:0] m_tdata
);
  import vsfb_pkg::*;

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic acc;
  assign acc = s_tvalid && s_tready;

  logic [7:0]  ld_bone;
  logic [4:0]  ld_elem;
  logic [31:0] ld_val, bones, weights;
  q16_t        vin [6];
  assign ld_bone = s_tdata[7:0];
  assign ld_elem = s_tdata[12:8];
  assign ld_val  = s_tdata[44:13];
  assign bones   = s_tdata[76:45];
  assign weights = s_tdata[108:77];
  for (genvar g = 0; g < 6; g++) begin : g_vin
    assign vin[g] = s_tdata[109 + 32*g +: 32];
  end

  // stage 1 registers; the store re-reads s1_bones while frozen
  logic        s1_v;
  logic [31:0] s1_bones, s1_w;
  q16_t        s1_vin [6];

  // ---------------- bone store: one RAM per influence and matrix word ------
  // Each influence has its own copy so four bones are read in the same cycle.
  logic        is_load;
  assign is_load = acc && (cmd_t'(s_tuser) == CMD_LOAD) && (ld_elem < 5'(MatWords));

  logic [31:0] mat [Influences][MatWords];
  for (genvar i = 0; i < Influences; i++) begin : g_inf
    for (genvar w = 0; w < MatWords; w++) begin : g_word
      vsfb_ram #(.Width(32), .Depth(MaxBones)) u_ram (
        .clk  (clk),
        .we   (is_load && ld_elem == 5'(w)),
        .waddr(ld_bone[BoneW-1:0]),
        .wdata(ld_val),
        .raddr(adv ? bones[8*i +: BoneW] : s1_bones[8*i +: BoneW]),
        .rdata(mat[i][w])
      );
    end
  end

  // ---------------- stage 1: data out of store ------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= acc && cmd_t'(s_tuser) == CMD_SKIN;
    end
    if (adv) begin
      s1_bones <= bones;
      s1_w     <= weights;
      s1_vin   <= vin;
    end
  end

  // ---------------- stage 2: rounded products -------------------------------
  // 18 products, 3 offsets each; position uses vin[0..2], normal vin[3..5].
  logic        s2_v;
  logic [7:0]  s2_w [Influences];
  logic signed [47:0] s2_p [Influences][MatWords];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      for (int i = 0; i < Influences; i++) begin
        s2_w[i] <= s1_w[8*i +: 8];
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            s2_p[i][r*4+c] <= 48'(( 64'(signed'(mat[i][r*4+c])) * 64'(s1_vin[c])
                               + 64'sd32768) >>> 16);
            s2_p[i][PosWords+r*3+c] <= 48'(( 64'(signed'(mat[i][PosWords+r*3+c]))
                               * 64'(s1_vin[3+c]) + 64'sd32768) >>> 16);
          end
          s2_p[i][r*4+3] <= 48'(signed'(mat[i][r*4+3]));
        end
      end
    end
  end

  // ---------------- stage 3: per-bone transformed rows ----------------------
  logic        s3_v;
  logic [7:0]  s3_w [Influences];
  logic signed [49:0] s3_t [Influences][6];
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
    if (adv) begin
      s3_w <= s2_w;
      for (int i = 0; i < Influences; i++) begin
        for (int r = 0; r < 3; r++) begin
          s3_t[i][r] <= 50'(s2_p[i][r*4]) + 50'(s2_p[i][r*4+1])
                      + 50'(s2_p[i][r*4+2]) + 50'(s2_p[i][r*4+3]);
          s3_t[i][3+r] <= 50'(s2_p[i][PosWords+r*3]) + 50'(s2_p[i][PosWords+r*3+1])
                        + 50'(s2_p[i][PosWords+r*3+2]);
        end
      end
    end
  end

  // ---------------- stage 4: weight products --------------------------------
  logic        s4_v;
  logic signed [58:0] s4_m [Influences][6];
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
    if (adv) begin
      for (int i = 0; i < Influences; i++) begin
        for (int k = 0; k < 6; k++) begin
          s4_m[i][k] <= 59'(s3_t[i][k]) * 59'($signed({1'b0, s3_w[i]}));
        end
      end
    end
  end

  // ---------------- stage 5: blend sum --------------------------------------
  logic        s5_v;
  logic [60:0] s5_mag [6];
  logic        s5_neg [6];
  always_ff @(posedge clk) begin
    logic signed [60:0] s;
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        s = 61'(s4_m[0][k]) + 61'(s4_m[1][k]) + 61'(s4_m[2][k]) + 61'(s4_m[3][k]);
        s5_neg[k] <= s[60];
        s5_mag[k] <= s[60] ? 61'(-s) : 61'(s);
      end
    end
  end

  // ---------------- stage 6/7: divide by 255 --------------------------------
  // q = floor(y/255) with y = m+127, rounding to nearest.
  // 1/255 = (1 + 2^-8 + 2^-16 + ...)/256: q0 = (y + (y>>8) + ... ) >> 8
  // lands on q or q-1; stage 7 compares the remainder and fixes it.
  logic        s6_v;
  logic [61:0] s6_y [6];
  logic [61:0] s6_q [6];
  logic        s6_neg [6];
  always_ff @(posedge clk) begin
    logic [61:0] y, t;
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
    if (adv) begin
      s6_neg <= s5_neg;
      for (int k = 0; k < 6; k++) begin
        y = 62'(s5_mag[k]) + 62'd127;
        t = y;
        for (int j = 1; j < 8; j++) t = t + (y >> (8*j));
        s6_y[k] <= y;
        s6_q[k] <= t >> 8;
      end
    end
  end

  logic        s7_v;
  q16_t        s7_b [6];
  always_ff @(posedge clk) begin
    logic [61:0] q, rem;
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        q = s6_q[k];
        rem = s6_y[k] - 62'(q * 62'd255);
        if (rem >= 62'd255) q = q + 62'd1;
        if (q == 62'd0) s7_b[k] <= '0;
        else if (!s6_neg[k] && q > 62'h7FFF_FFFF) s7_b[k] <= 32'sh7FFF_FFFF;
        else if (s6_neg[k] && q > 62'h8000_0000) s7_b[k] <= 32'sh8000_0000;
        else s7_b[k] <= s6_neg[k] ? 32'(-q) : 32'(q);
      end
    end
  end

  // ---------------- stage 8: normal magnitudes and scale --------------------
  // magnitude reaches 2^31 for a saturated negative component
  logic        s8_v;
  q16_t        s8_pos [3];
  logic [31:0] s8_mag [3];
  logic        s8_neg [3];
  logic        s8_zero;
  always_ff @(posedge clk) begin
    logic [31:0] m [3];
    logic [31:0] mx;
    logic [4:0]  sh;
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= s7_v;
    end
    if (adv) begin
      mx = '0;
      for (int r = 0; r < 3; r++) begin
        m[r] = s7_b[3+r][31] ? 32'(-s7_b[3+r]) : 32'(s7_b[3+r]);
        if (m[r] > mx) mx = m[r];
        s8_neg[r] <= s7_b[3+r][31];
        s8_pos[r] <= s7_b[r];
      end
      sh = '0;
      for (int b = 0; b < 31; b++) if (mx[b]) sh = 5'(30 - b);
      if (mx[31]) sh = '0;
      for (int r = 0; r < 3; r++) s8_mag[r] <= m[r] << sh;
      s8_zero <= (mx == '0);
    end
  end

  // ---------------- stage 9: sum of squares ---------------------------------
  logic        s9_v;
  q16_t        s9_pos [3];
  logic [31:0] s9_mag [3];
  logic        s9_neg [3];
  logic        s9_zero;
  logic [63:0] s9_sum;
  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= s8_v;
    end
    if (adv) begin
      s9_pos <= s8_pos; s9_mag <= s8_mag; s9_neg <= s8_neg; s9_zero <= s8_zero;
      s9_sum <= 64'(s8_mag[0]) * 64'(s8_mag[0]) + 64'(s8_mag[1]) * 64'(s8_mag[1])
              + 64'(s8_mag[2]) * 64'(s8_mag[2]);
    end
  end

  // ---------------- square root: 32 pipelined steps -------------------------
  localparam int SqSteps = 32;
  logic        sq_v   [SqSteps+1];
  logic [63:0] sq_n   [SqSteps+1];
  logic [63:0] sq_r   [SqSteps+1];
  q16_t        sq_pos [SqSteps+1][3];
  logic [31:0] sq_mag [SqSteps+1][3];
  logic        sq_neg [SqSteps+1][3];
  logic        sq_zero[SqSteps+1];
  assign sq_v[0] = s9_v;
  assign sq_n[0] = s9_sum;
  assign sq_r[0] = '0;
  assign sq_pos[0] = s9_pos;
  assign sq_mag[0] = s9_mag;
  assign sq_neg[0] = s9_neg;
  assign sq_zero[0] = s9_zero;
  for (genvar j = 0; j < SqSteps; j++) begin : g_sq
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*j);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v[j+1] <= sq_v[j];
      end
      if (adv) begin
        sq_pos[j+1] <= sq_pos[j]; sq_mag[j+1] <= sq_mag[j];
        sq_neg[j+1] <= sq_neg[j]; sq_zero[j+1] <= sq_zero[j];
        if (sq_n[j] >= sq_r[j] + Bit) begin
          sq_n[j+1] <= sq_n[j] - (sq_r[j] + Bit);
          sq_r[j+1] <= (sq_r[j] >> 1) + Bit;
        end else begin
          sq_n[j+1] <= sq_n[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
      end
    end
  end

  // ---------------- division: 18 restoring steps per component -------------
  // o = (mag*65536 + len/2) / len; quotient <= 65536 fits in 18 bits.
  localparam int DvSteps = 18;
  logic        dv_v   [DvSteps+1];
  logic [31:0] dv_len [DvSteps+1];
  logic [48:0] dv_rem [DvSteps+1][3];
  logic [17:0] dv_q   [DvSteps+1][3];
  q16_t        dv_pos [DvSteps+1][3];
  logic        dv_neg [DvSteps+1][3];
  logic        dv_zero[DvSteps+1];
  assign dv_v[0]   = sq_v[SqSteps];
  assign dv_len[0] = 32'(sq_r[SqSteps]);
  assign dv_pos[0] = sq_pos[SqSteps];
  assign dv_neg[0] = sq_neg[SqSteps];
  assign dv_zero[0] = sq_zero[SqSteps];
  for (genvar r = 0; r < 3; r++) begin : g_dv0
    assign dv_rem[0][r] = 49'({sq_mag[SqSteps][r], 16'd0}) + 49'(sq_r[SqSteps][31:1]);
    assign dv_q[0][r]   = '0;
  end
  for (genvar j = 0; j < DvSteps; j++) begin : g_dv
    localparam int Sh = DvSteps - 1 - j;
    always_ff @(posedge clk) begin
      logic [48:0] d;
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (adv) begin
        dv_len[j+1] <= dv_len[j]; dv_pos[j+1] <= dv_pos[j];
        dv_neg[j+1] <= dv_neg[j]; dv_zero[j+1] <= dv_zero[j];
        d = 49'(dv_len[j]) << Sh;
        for (int r = 0; r < 3; r++) begin
          if (dv_rem[j][r] >= d) begin
            dv_rem[j+1][r] <= dv_rem[j][r] - d;
            dv_q[j+1][r]   <= dv_q[j][r] | (18'd1 << Sh);
          end else begin
            dv_rem[j+1][r] <= dv_rem[j][r];
            dv_q[j+1][r]   <= dv_q[j][r];
          end
        end
      end
    end
  end

  // ---------------- output register ----------------------------------------
  logic [17:0] nout [3];
  always_comb begin
    logic [17:0] o;
    for (int r = 0; r < 3; r++) begin
      o = (dv_q[DvSteps][r] > 18'd65536) ? 18'd65536 : dv_q[DvSteps][r];
      if (dv_zero[DvSteps]) nout[r] = '0;
      else nout[r] = dv_neg[DvSteps][r] ? 18'(-o) : o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_v[DvSteps];
    end
    if (adv && dv_v[DvSteps]) begin
      m_tdata <= OutBytesW'({nout[2], nout[1], nout[0],
                             dv_pos[DvSteps][2], dv_pos[DvSteps][1], dv_pos[DvSteps][0]});
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready not tied to output space");
  a_load_no_s1: assert property (@(posedge clk) disable iff (rst)
    acc && cmd_t'(s_tuser) == CMD_LOAD |=> !s1_v)
    else $error("load request entered skin pipeline");
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[113:96]) <= 18'sd65536)
                 && ($signed(m_tdata[113:96]) >= -18'sd65536))
    else $error("normal out of range");
`endif
endmodule

>>> tb/sv/vsfb_checker.sv
// ----------------------------------------------------------------------------
// vsfb_checker: skinning result predictor and scoreboard
// Mirrors the bone store from load requests, predicts each skin result and
// compares it field by field with what leaves the master side.
// ----------------------------------------------------------------------------
module vsfb_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic s_tuser,
  input  logic [vsfb_pkg::InBytesW-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [vsfb_pkg::OutBytesW-1:0] m_tdata,
  output int   fail_count,
  output int   pending
);
  import vsfb_pkg::*;

  typedef struct packed {
    logic signed [17:0] nz, ny, nx;
    logic signed [31:0] pz, py, px;
  } vertex_out_t;

  logic signed [31:0] pos_store [MaxBones*PosWords];
  logic signed [31:0] rot_store [MaxBones*RotWords];
  vertex_out_t skinned_q[$];

  assign pending = skinned_q.size();

  function automatic longint mul_round(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint blend_div(longint s);
    longint mag;
    mag = (s < 0) ? -s : s;
    mag = (mag + 127) / 255;
    mag = (s < 0) ? -mag : mag;
    if (mag > 64'sd2147483647) mag = 64'sd2147483647;
    if (mag < -64'sd2147483648) mag = -64'sd2147483648;
    return mag;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vertex_out_t skin_vertex(logic [InBytesW-1:0] d);
    longint p[3], n[3], ap[3], an[3], bn[3], tv, tn, w, o;
    longint unsigned mag[3], mx, sum, len;
    int b, base_p, base_r;
    vertex_out_t res;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(d[109 + 32*i +: 32]);
      n[i] = $signed(d[205 + 32*i +: 32]);
      ap[i] = 0;
      an[i] = 0;
    end
    for (int i = 0; i < Influences; i++) begin
      w = longint'(d[77 + 8*i +: 8]);
      b = int'(d[45 + 8*i +: 8]);
      if (w != 0) begin
        base_p = b * PosWords;
        base_r = b * RotWords;
        for (int r = 0; r < 3; r++) begin
          tv = mul_round(pos_store[base_p+r*4], p[0]) + mul_round(pos_store[base_p+r*4+1], p[1])
             + mul_round(pos_store[base_p+r*4+2], p[2]) + longint'(pos_store[base_p+r*4+3]);
          tn = mul_round(rot_store[base_r+r*3], n[0]) + mul_round(rot_store[base_r+r*3+1], n[1])
             + mul_round(rot_store[base_r+r*3+2], n[2]);
          ap[r] += tv * w;
          an[r] += tn * w;
        end
      end
    end
    res.px = 32'(blend_div(ap[0]));
    res.py = 32'(blend_div(ap[1]));
    res.pz = 32'(blend_div(ap[2]));
    mx = 0;
    for (int r = 0; r < 3; r++) begin
      bn[r] = blend_div(an[r]);
      mag[r] = (bn[r] < 0) ? -bn[r] : bn[r];
      if (mag[r] > mx) mx = mag[r];
    end
    res.nx = 0;
    res.ny = 0;
    res.nz = 0;
    if (mx != 0) begin
      // scale so the largest magnitude lands in [2^30, 2^31]
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int r = 0; r < 3; r++) mag[r] <<= 1;
      end
      sum = 0;
      for (int r = 0; r < 3; r++) sum += mag[r] * mag[r];
      len = root_floor(sum);
      for (int r = 0; r < 3; r++) begin
        o = (mag[r] * 65536 + len / 2) / len;
        if (o > 65536) o = 65536;
        if (bn[r] < 0) o = -o;
        case (r)
          0: res.nx = 18'(o);
          1: res.ny = 18'(o);
          default: res.nz = 18'(o);
        endcase
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vertex_out_t got, want;
    int bone, elem;
    if (rst) begin
      skinned_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[OutW-1:0];
        if (skinned_q.size() == 0) begin
          $display("unexpected vertex result at %0t", $realtime);
          fail_count++;
        end else begin
          want = skinned_q.pop_front();
          if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
          if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
          if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
          if (got.nx != want.nx) report_mismatch("norm_x", got.nx, want.nx);
          if (got.ny != want.ny) report_mismatch("norm_y", got.ny, want.ny);
          if (got.nz != want.nz) report_mismatch("norm_z", got.nz, want.nz);
        end
      end
      if (s_tvalid && s_tready) begin
        if (cmd_t'(s_tuser) == CMD_SKIN) begin
          skinned_q.insert(skinned_q.size(), skin_vertex(s_tdata));
        end else begin
          bone = int'(s_tdata[7:0]);
          elem = int'(s_tdata[12:8]);
          if (elem < PosWords) pos_store[bone*PosWords + elem] = s_tdata[44:13];
          else if (elem < MatWords) rot_store[bone*RotWords + elem - PosWords] = s_tdata[44:13];
        end
      end
    end
  end
endmodule

>>> tb/sv/vertex_skinning_four_bone_unit_test.sv
// ----------------------------------------------------------------------------
// vertex_skinning_four_bone_unit_test: stimulus and verdict
// Fills a set of bones, then streams directed and random load and skin
// requests with bursty input, stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
module vertex_skinning_four_bone_unit_test;
  import vsfb_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [InBytesW-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OutBytesW-1:0] m_tdata;
  int fail_count, pending;
  int cycles;
  bit hold_off;    // long receiver hold-off, set by stimulus

  vertex_skinning_four_bone_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata
  );

  vsfb_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: own stall pattern, plus the hold-off stretch
  initial begin
    int mode;
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 20)) begin
        case (mode)
          0: m_tready <= 1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 1) != 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  int burst_left;

  // offer one request and hold it until accepted; gaps fall between bursts
  task automatic send_request(cmd_t cmd, logic [InBytesW-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_word(int bone, int elem, logic [31:0] val);
    logic [InBytesW-1:0] d;
    d = '0;
    for (int i = 0; i < InBytesW / 32; i++) d[i*32 +: 32] = $urandom;  // skin fields are don't-care
    d[7:0] = 8'(bone);
    d[12:8] = 5'(elem);
    d[44:13] = val;
    send_request(CMD_LOAD, d);
  endtask

  // skins only reference bones 0-3 and 252-255, which are filled in full
  function automatic logic [7:0] rand_bone();
    int k;
    k = $urandom_range(0, 7);
    return (k < 4) ? 8'(k) : 8'(248 + k);
  endfunction

  function automatic logic [31:0] rand_bones();
    return {rand_bone(), rand_bone(), rand_bone(), rand_bone()};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [31:0] rand_matrix_word();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h0001_0000;
      2: return 32'h0;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic skin_vertex(logic [31:0] bones, logic [31:0] weights,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    logic [InBytesW-1:0] d;
    d = '0;
    d[44:0] = 45'({$urandom, $urandom});  // load fields are ignored by a skin
    d[76:45] = bones;
    d[108:77] = weights;
    d[109 +: 96] = {pz, py, px};
    d[205 +: 96] = {nz, ny, nx};
    send_request(CMD_SKIN, d);
  endtask

  function automatic logic [31:0] rand_weights();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return {24'h0, 8'hff};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tuser = CMD_LOAD;
    s_tdata = '0;
    burst_left = 0;
    cycles = 0;
    hold_off = 0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // fill the bone set in full so no skin ever reads an unwritten word
    for (int k = 0; k < 8; k++)
      for (int e = 0; e < MatWords; e++)
        load_word((k < 4) ? k : 248 + k, e,
                  ($urandom_range(0, 3) == 0) ? 32'h0001_0000 : rand_matrix_word());

    // directed: identity on bone 0, extremes, zero weights, zero normal, wrap
    for (int e = 0; e < MatWords; e++)
      load_word(0, e, (e == 0 || e == 5 || e == 10 || e == 12 || e == 16 || e == 20)
                ? 32'h0001_0000 : 32'h0);
    load_word(1, 3, 32'h7fff_ffff);
    load_word(1, 0, 32'h8000_0000);
    load_word(2, 21, 32'hdead_beef);  // out of range element is dropped
    load_word(2, 31, 32'h1234_5678);
    load_word(255, 20, 32'hffff_0000);
    skin_vertex(32'h0, 32'h0000_00ff, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000,
                32'h0001_0000, 32'h0, 32'h0);
    skin_vertex(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1, 32'h1, 32'h1);
    skin_vertex(32'h0, 32'h0000_00ff, 32'h5, 32'h6, 32'h7, 32'h0, 32'h0, 32'h0);
    skin_vertex(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    skin_vertex(32'h0102_0301, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    skin_vertex(32'h00ff_0100, 32'h0100_ff01, 32'hffff_ffff, 32'h0, 32'h1,
                32'hffff_ffff, 32'h0, 32'h0);
    skin_vertex(32'h0, 32'h0000_00ff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3);

    // long receiver hold-off with the sender streaming skins
    hold_off = 1;
    for (int i = 0; i < 40; i++)
      skin_vertex(rand_bones(), rand_weights(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());

    // random mix, mostly skins
    for (int i = 0; i < 310; i++) begin
      if ($urandom_range(0, 4) == 0)
        load_word(rand_bone(), $urandom_range(0, 31), rand_matrix_word());
      else
        skin_vertex(rand_bones(), rand_weights(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
    end
    s_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> files.f
src/vsfb_pkg.sv
src/vsfb_ram.sv
src/vertex_skinning_four_bone_unit.sv
tb/sv/vsfb_checker.sv
tb/sv/vertex_skinning_four_bone_unit_test.sv
